@@ design/fasi_pkg.sv @@
// Shared constants, field positions and types for the five-axis servo interpolator.
// Used by fasi_div and five_axis_servo_interpolator_top; no dependencies.
`default_nettype none

package fasi_pkg;

   localparam int AXIS_COUNT  = 5;
   localparam int ANGLE_W     = 8;
   localparam int MAX_ANGLE   = 180;
   localparam int RESET_ANGLE = 90;
   localparam int SPEED_W     = 16;
   localparam int STEP_W      = 14;
   localparam int INC_W       = ANGLE_W + 1;
   localparam int TICK_RATE   = 50;
   localparam int AXIS_W      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int DIV_CNT_W   = $clog2(STEP_W);

   localparam int SPEED_LSB   = AXIS_COUNT * ANGLE_W;
   localparam int SNAP_BIT    = SPEED_LSB + SPEED_W;
   localparam int MOTION_BIT  = AXIS_COUNT * ANGLE_W;
   localparam int REQ_TDATA_W = ((SNAP_BIT + 1 + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((MOTION_BIT + 1 + 7) / 8) * 8;

   localparam logic MODE_MOVE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef logic [ANGLE_W-1:0]       angle_type;
   typedef logic signed [INC_W-1:0]  inc_type;

   typedef struct packed {
      logic               start;
      logic [STEP_W-1:0]  dividend;
      logic [SPEED_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [STEP_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ design/five_axis_servo_interpolator_top.sv @@
// Top level of the five-axis servo interpolator: sequencer, axis registers and output stage.
// Depends on fasi_pkg and instantiates the shared divider fasi_div.
//
// Keeps five servo angles (reset 90) and walks them toward commanded targets in equal
// per-axis increments, one per tick transaction (tuser = 1), finishing with an exact snap.
// A move transaction (tuser = 0) scans the five axes for the largest change; unless
// snap_now is set or the speed is zero, it then divides for the step count and, if that is
// nonzero, for one increment per axis (six divisions in all), through one shared divider
// that resolves one quotient bit per cycle, 14 bits each. req_tready is low while a
// transaction is in work; the result sits in an output register, one result per transaction.
`default_nettype none

module five_axis_servo_interpolator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // target_base, target_bicep, target_elbow, target_wrist, target_gripper,
   // move_speed, snap_now, zero pad
   input  logic [fasi_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // angle_base, angle_bicep, angle_elbow, angle_wrist, angle_gripper, in_motion, zero pad
   output logic [fasi_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import fasi_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_CNT_WAIT  = 3'd2;
   localparam logic [2:0] S_INC_START = 3'd3;
   localparam logic [2:0] S_INC_WAIT  = 3'd4;
   localparam logic [2:0] S_APPLY     = 3'd5;
   localparam logic [2:0] S_EMIT      = 3'd6;

   logic [2:0]             state_ff, state_in;
   angle_type              cur_ff     [AXIS_COUNT];
   angle_type              cur_in     [AXIS_COUNT];
   angle_type              goal_ff    [AXIS_COUNT];
   angle_type              goal_in    [AXIS_COUNT];
   inc_type                inc_ff     [AXIS_COUNT];
   inc_type                inc_in     [AXIS_COUNT];
   angle_type              stepped    [AXIS_COUNT];
   logic [STEP_W-1:0]      steps_ff, steps_in;
   logic                   moving_ff, moving_in;
   logic [AXIS_W-1:0]      axis_ff, axis_in;
   angle_type              maxabs_ff, maxabs_in;
   logic [STEP_W-1:0]      count_ff, count_in;
   logic                   snap_ff, snap_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   last_axis;
   logic signed [INC_W-1:0] sel_delta;
   logic                   sel_neg;
   logic [INC_W-1:0]       sel_mag;
   angle_type              sel_abs;
   angle_type              max_next;
   inc_type                quo_mag;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   fasi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      sel_delta = $signed({1'b0, goal_ff[axis_ff]}) - $signed({1'b0, cur_ff[axis_ff]});
      sel_neg   = sel_delta[INC_W-1];
      sel_mag   = sel_neg ? (-sel_delta) : sel_delta;
      sel_abs   = sel_mag[ANGLE_W-1:0];
      max_next  = (sel_abs > maxabs_ff) ? sel_abs : maxabs_ff;
      last_axis = (axis_ff == AXIS_W'(AXIS_COUNT - 1));
      quo_mag   = inc_type'({1'b0, div_rsp.quotient[ANGLE_W-1:0]});
   end

   always_comb begin
      logic signed [INC_W:0] sum;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         sum = $signed({2'b00, cur_ff[i]}) + $signed({inc_ff[i][INC_W-1], inc_ff[i]});
         if (sum[INC_W]) begin
            stepped[i] = '0;
         end else if (sum[INC_W-1:0] > INC_W'(MAX_ANGLE)) begin
            stepped[i] = ANGLE_W'(MAX_ANGLE);
         end else begin
            stepped[i] = sum[ANGLE_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      goal_in      = goal_ff;
      inc_in       = inc_ff;
      steps_in     = steps_ff;
      moving_in    = moving_ff;
      axis_in      = axis_ff;
      maxabs_in    = maxabs_ff;
      count_in     = count_ff;
      snap_in      = snap_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == MODE_TICK) begin
                  if (moving_ff) begin
                     if (steps_ff != '0) begin
                        cur_in   = stepped;
                        steps_in = steps_ff - STEP_W'(1);
                     end else begin
                        cur_in    = goal_ff;
                        moving_in = 1'b0;
                     end
                  end
                  state_in = S_EMIT;
               end else begin
                  for (int i = 0; i < AXIS_COUNT; i++) begin
                     if (req_tdata[i*ANGLE_W +: ANGLE_W] > ANGLE_W'(MAX_ANGLE)) begin
                        goal_in[i] = ANGLE_W'(MAX_ANGLE);
                     end else begin
                        goal_in[i] = req_tdata[i*ANGLE_W +: ANGLE_W];
                     end
                  end
                  snap_in   = req_tdata[SNAP_BIT];
                  speed_in  = req_tdata[SPEED_LSB +: SPEED_W];
                  axis_in   = '0;
                  maxabs_in = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            maxabs_in = max_next;
            if (last_axis) begin
               if (snap_ff || (speed_ff == '0)) begin
                  cur_in    = goal_ff;
                  steps_in  = '0;
                  moving_in = 1'b0;
                  state_in  = S_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = STEP_W'(max_next) * STEP_W'(TICK_RATE);
                  div_req.divisor  = speed_ff;
                  state_in         = S_CNT_WAIT;
               end
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end
         S_CNT_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  cur_in    = goal_ff;
                  steps_in  = '0;
                  moving_in = 1'b0;
                  state_in  = S_EMIT;
               end else begin
                  count_in = div_rsp.quotient;
                  axis_in  = '0;
                  state_in = S_INC_START;
               end
            end
         end
         S_INC_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = STEP_W'(sel_abs);
            div_req.divisor  = SPEED_W'(count_ff);
            state_in         = S_INC_WAIT;
         end
         S_INC_WAIT: begin
            if (div_rsp.done) begin
               inc_in[axis_ff] = sel_neg ? (-quo_mag) : quo_mag;
               if (last_axis) begin
                  state_in = S_APPLY;
               end else begin
                  axis_in  = axis_ff + AXIS_W'(1);
                  state_in = S_INC_START;
               end
            end
         end
         S_APPLY: begin
            cur_in    = stepped;
            steps_in  = count_ff - STEP_W'(1);
            moving_in = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  rsp_data_in[i*ANGLE_W +: ANGLE_W] = cur_ff[i];
               end
               rsp_data_in[MOTION_BIT] = moving_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         steps_ff     <= '0;
         moving_ff    <= 1'b0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            cur_ff[i]  <= ANGLE_W'(RESET_ANGLE);
            goal_ff[i] <= ANGLE_W'(RESET_ANGLE);
            inc_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         moving_ff    <= moving_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         goal_ff      <= goal_in;
         inc_ff       <= inc_in;
      end
      maxabs_ff   <= maxabs_in;
      count_ff    <= count_in;
      snap_ff     <= snap_in;
      speed_ff    <= speed_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_rsp.busy)
      else $error("divider busy while accepting a transaction");

   a_idle_no_steps: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |-> (steps_ff == '0))
      else $error("steps left without an active move");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == S_CNT_WAIT) || (state_ff == S_INC_WAIT)))
      else $error("divider result outside a wait state");

   for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_chk
      a_angle_range: assert property (@(posedge clock) disable iff (reset)
         cur_ff[g] <= ANGLE_W'(MAX_ANGLE))
         else $error("axis angle above limit");
   end

endmodule

`default_nettype wire

@@ design/fasi_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on fasi_pkg for operand widths and the request/response structs.
`default_nettype none

module fasi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fasi_pkg::div_req_type div_req,
   output fasi_pkg::div_rsp_type div_rsp
);
   import fasi_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SPEED_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]    quo_ff, quo_in;
   logic [SPEED_W-1:0]   divisor_ff, divisor_in;
   logic [SPEED_W:0]     rem_shift;
   logic [SPEED_W+1:0]   trial;

   always_comb begin
      rem_shift  = {rem_ff, quo_ff[STEP_W-1]};
      trial      = {1'b0, rem_shift} - {2'b00, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[SPEED_W+1]) begin
            rem_in = trial[SPEED_W-1:0];
            quo_in = {quo_ff[STEP_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[SPEED_W-1:0];
            quo_in = {quo_ff[STEP_W-2:0], 1'b0};
         end
         if (cnt_ff == DIV_CNT_W'(STEP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire
